[src/dqe_pkg.sv]
// Shared types, codes and constants for the deadline expiry queue.
package dqe_pkg;

   localparam int CAPACITY = 16;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_DUP  = 2'd2;

   localparam logic [63:0] NEVER_TIME_RESET = '1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  task_id;
      logic [63:0] deadline;
      logic [31:0] order_seq;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        popped_valid;
      logic [7:0]  popped_task;
      logic [63:0] popped_deadline;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] deadline;
      logic [31:0] order_seq;
      logic [7:0]  task_id;
   } entry_type;

   typedef struct packed {
      logic less;
      logic match;
   } cell_flags_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_LEFT,
      OP_RIGHT
   } cell_op_type;

endpackage

[src/dqe_cell.sv]
// One cell of the sorted queue: holds one entry, compares it and shifts.
module dqe_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmp_en,
   input  dqe_pkg::entry_type      req_entry,
   input  dqe_pkg::cell_op_type    op,
   input  dqe_pkg::entry_type      left_entry,
   input  dqe_pkg::entry_type      right_entry,
   output dqe_pkg::entry_type      entry,
   output dqe_pkg::cell_flags_type flags
);

   dqe_pkg::entry_type      entry_ff;
   dqe_pkg::cell_flags_type flags_ff;
   dqe_pkg::cell_flags_type flags_in;

   always_comb begin
      flags_in.less  = !entry_ff.valid ||
                       ({req_entry.deadline, req_entry.order_seq, req_entry.task_id} <
                        {entry_ff.deadline, entry_ff.order_seq, entry_ff.task_id});
      flags_in.match = entry_ff.valid && (entry_ff.task_id == req_entry.task_id);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         case (op)
            dqe_pkg::OP_LOAD: begin
               entry_ff       <= req_entry;
               entry_ff.valid <= 1'b1;
            end
            dqe_pkg::OP_LEFT:  entry_ff <= left_entry;
            dqe_pkg::OP_RIGHT: entry_ff <= right_entry;
            default:           entry_ff <= entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

[src/deadline_expiry_queue.sv]
// Top level of the deadline expiry queue: control, cell row and response register.
//
// Commands arrive on the req_ channel (valid/ready) as one transaction each:
// insert, remove by task id, or pop the earliest entry if its deadline is at
// or before now_time. Every transaction returns exactly one result on the
// rsp_ channel. Entries live in a row of cells kept sorted by deadline, then
// sequence number, then task id, with the minimum in the first cell.
// A transaction passes through three steps: capture, a compare of all cells'
// entries against it, and a shift of the row with a load of the result register.
// A new transaction is taken only once the last one has left the shift step.
// The result is registered in the shift step. A waiting result does not
// block acceptance; if the receiver stalls, the shift step waits until the
// result register is free. The user must write the never_time register through
// the csr_ port only while idle; the block itself does not enforce this. Reset
// empties the queue, sets never_time to all ones and drops any pending result.
module deadline_expiry_queue #(
   parameter int CAPACITY = dqe_pkg::CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dqe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dqe_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [63:0]      csr_wr_data
);

   localparam int LEVELS = $clog2(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_APPLY
   } state_type;

   state_type               state_ff;
   dqe_pkg::req_type        req_ff;
   dqe_pkg::rsp_type        rsp_ff;
   dqe_pkg::rsp_type        rsp_in;
   logic                    rsp_valid_ff;
   logic [63:0]             never_ff;

   dqe_pkg::entry_type      req_entry;
   dqe_pkg::entry_type      ent       [CAPACITY];
   dqe_pkg::entry_type      left_ent  [CAPACITY];
   dqe_pkg::entry_type      right_ent [CAPACITY];
   dqe_pkg::cell_flags_type flg       [CAPACITY];
   dqe_pkg::cell_op_type    op        [CAPACITY];

   logic [CAPACITY-1:0]     match_vec;
   logic [CAPACITY-1:0]     less_vec;
   logic [CAPACITY-1:0]     pfx;
   logic [CAPACITY-1:0]     pfx_tmp;
   logic                    fire;
   logic                    is_never;
   logic                    dup;
   logic                    full;
   logic                    do_insert;
   logic                    do_remove;
   logic                    do_pop;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      req_entry.valid     = 1'b1;
      req_entry.deadline  = req_ff.deadline;
      req_entry.order_seq = req_ff.order_seq;
      req_entry.task_id   = req_ff.task_id;
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i] = flg[i].match;
         less_vec[i]  = flg[i].less;
         left_ent[i]  = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
         right_ent[i] = (i == CAPACITY - 1) ? '0 : ent[(i == CAPACITY - 1) ? i : i + 1];
      end
   end

   // log-depth prefix OR: cells at or after the matching one load from their right neighbour
   always_comb begin
      pfx = match_vec;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         pfx_tmp = pfx;
         for (int i = 0; i < CAPACITY; i++) begin
            if (i >= (1 << lvl)) begin
               pfx[i] = pfx_tmp[i] | pfx_tmp[i - (1 << lvl)];
            end
         end
      end
   end

   always_comb begin
      fire      = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
      is_never  = (req_ff.deadline == never_ff);
      dup       = |match_vec;
      full      = ent[CAPACITY-1].valid;
      do_insert = (req_ff.cmd == dqe_pkg::CMD_INSERT) && !is_never && !dup && !full;
      do_remove = (req_ff.cmd == dqe_pkg::CMD_REMOVE);
      do_pop    = (req_ff.cmd == dqe_pkg::CMD_POP) && ent[0].valid &&
                  (ent[0].deadline <= req_ff.now_time);

      rsp_in = '0;
      if ((req_ff.cmd == dqe_pkg::CMD_INSERT) && !is_never) begin
         if (dup) begin
            rsp_in.status = dqe_pkg::STATUS_DUP;
         end else if (full) begin
            rsp_in.status = dqe_pkg::STATUS_FULL;
         end else begin
            rsp_in.status = dqe_pkg::STATUS_OK;
         end
      end
      if (do_pop) begin
         rsp_in.popped_valid    = 1'b1;
         rsp_in.popped_task     = ent[0].task_id;
         rsp_in.popped_deadline = ent[0].deadline;
      end

      for (int i = 0; i < CAPACITY; i++) begin
         op[i] = dqe_pkg::OP_HOLD;
         if (fire) begin
            if (do_insert && less_vec[i]) begin
               if (i == 0) begin
                  op[i] = dqe_pkg::OP_LOAD;
               end else if (!less_vec[(i == 0) ? 0 : i - 1]) begin
                  op[i] = dqe_pkg::OP_LOAD;
               end else begin
                  op[i] = dqe_pkg::OP_LEFT;
               end
            end else if (do_remove && pfx[i]) begin
               op[i] = dqe_pkg::OP_RIGHT;
            end else if (do_pop) begin
               op[i] = dqe_pkg::OP_RIGHT;
            end
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      dqe_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmp_en      (state_ff == ST_CMP),
         .req_entry   (req_entry),
         .op          (op[g]),
         .left_entry  (left_ent[g]),
         .right_entry (right_ent[g]),
         .entry       (ent[g]),
         .flags       (flg[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         never_ff <= dqe_pkg::NEVER_TIME_RESET;
      end else if (csr_wr_en) begin
         never_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (fire) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[bench/tb_top.sv]
// Testbench for deadline_expiry_queue: table-driven and random transactions, queue predictor.
module tb_top;

   localparam logic [1:0]  CMD_SPARE   = 2'd3;
   localparam logic [63:0] MAX_TIME    = '1;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLD_CYCLES = 150;

   typedef struct {
      dqe_pkg::req_type item;
      bit               fixed;
      dqe_pkg::rsp_type want;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dqe_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dqe_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [63:0]      csr_wr_data = '0;

   // shadow of the queue contents
   bit          held [dqe_pkg::CAPACITY];
   logic [63:0] held_deadline [dqe_pkg::CAPACITY];
   logic [31:0] held_seq [dqe_pkg::CAPACITY];
   logic [7:0]  held_task [dqe_pkg::CAPACITY];
   logic [63:0] never_value = MAX_TIME;

   dqe_pkg::rsp_type due_results [$];
   script_row_type   script [$];
   logic [63:0]      now_ns = 64'h1000;
   bit               calm = 1'b0;
   bit               hold_wanted = 1'b0;
   bit               hold_done = 1'b0;
   int               hold_left = 0;
   int               fault_count = 0;
   int               cycle_count = 0;

   deadline_expiry_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int locate_task(logic [7:0] id);
      for (int i = 0; i < dqe_pkg::CAPACITY; i++)
         if (held[i] && held_task[i] == id) return i;
      return -1;
   endfunction

   function automatic dqe_pkg::rsp_type predict_outcome(dqe_pkg::req_type t);
      dqe_pkg::rsp_type r;
      int               k;
      r = '0;
      k = -1;
      case (t.cmd)
         dqe_pkg::CMD_INSERT: begin
            if (t.deadline != never_value) begin
               if (locate_task(t.task_id) >= 0) begin
                  r.status = dqe_pkg::STATUS_DUP;
               end else begin
                  for (int i = dqe_pkg::CAPACITY - 1; i >= 0; i--)
                     if (!held[i]) k = i;
                  if (k < 0) begin
                     r.status = dqe_pkg::STATUS_FULL;
                  end else begin
                     held[k]          = 1'b1;
                     held_deadline[k] = t.deadline;
                     held_seq[k]      = t.order_seq;
                     held_task[k]     = t.task_id;
                  end
               end
            end
         end
         dqe_pkg::CMD_REMOVE: begin
            k = locate_task(t.task_id);
            if (k >= 0) held[k] = 1'b0;
         end
         dqe_pkg::CMD_POP: begin
            // earliest by deadline, then sequence, then task id
            for (int i = 0; i < dqe_pkg::CAPACITY; i++)
               if (held[i] && (k < 0 || {held_deadline[i], held_seq[i], held_task[i]} <
                               {held_deadline[k], held_seq[k], held_task[k]}))
                  k = i;
            if (k >= 0 && held_deadline[k] <= t.now_time) begin
               r.popped_valid    = 1'b1;
               r.popped_task     = held_task[k];
               r.popped_deadline = held_deadline[k];
               held[k]           = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic dqe_pkg::req_type make_req(logic [1:0] cmd, logic [7:0] id,
                                                 logic [63:0] dl, logic [31:0] seq,
                                                 logic [63:0] now);
      dqe_pkg::req_type t;
      t.cmd       = cmd;
      t.task_id   = id;
      t.deadline  = dl;
      t.order_seq = seq;
      t.now_time  = now;
      return t;
   endfunction

   function automatic script_row_type fixed_row(dqe_pkg::req_type t, logic [1:0] st,
                                                logic pv, logic [7:0] pt,
                                                logic [63:0] pd);
      script_row_type row;
      row.item                 = t;
      row.fixed                = 1'b1;
      row.want.status          = st;
      row.want.popped_valid    = pv;
      row.want.popped_task     = pt;
      row.want.popped_deadline = pd;
      return row;
   endfunction

   function automatic script_row_type open_row(dqe_pkg::req_type t);
      script_row_type row;
      row.item  = t;
      row.fixed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic dqe_pkg::req_type random_command(int insert_pct);
      dqe_pkg::req_type t;
      int               roll;
      roll = $urandom_range(99);
      if (roll < insert_pct) t.cmd = dqe_pkg::CMD_INSERT;
      else if (roll < insert_pct + 15) t.cmd = dqe_pkg::CMD_REMOVE;
      else if (roll < 98) t.cmd = dqe_pkg::CMD_POP;
      else t.cmd = CMD_SPARE;
      t.task_id = ($urandom_range(99) < 80) ? 8'($urandom_range(23)) : 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 60) t.deadline = now_ns + 64'($urandom_range(200));
      else if (roll < 70) t.deadline = never_value;
      else if (roll < 75) t.deadline = '0;
      else if (roll < 80) t.deadline = MAX_TIME - 64'($urandom_range(1));
      else t.deadline = {$urandom, $urandom};
      t.order_seq = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : 32'($urandom);
      roll = $urandom_range(99);
      if (roll < 60) t.now_time = now_ns + 64'($urandom_range(200)) - 64'd100;
      else if (roll < 70) t.now_time = MAX_TIME;
      else if (roll < 80) t.now_time = '0;
      else t.now_time = {$urandom, $urandom};
      now_ns = now_ns + 64'($urandom_range(20));
      return t;
   endfunction

   task automatic report_fault(string what, dqe_pkg::rsp_type want, dqe_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= 10)
         $display("%s: want st=%0d pv=%0d task=%0h dl=%0h / got st=%0d pv=%0d task=%0h dl=%0h",
                  what, want.status, want.popped_valid, want.popped_task,
                  want.popped_deadline, got.status, got.popped_valid, got.popped_task,
                  got.popped_deadline);
   endtask

   // one transaction on the request side
   task automatic offer(script_row_type row);
      dqe_pkg::rsp_type outcome;
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 9);
      end
      req_valid <= 1'b1;
      req_data  <= row.item;
      do @(posedge clock); while (!req_ready);
      outcome = predict_outcome(row.item);
      due_results.push_back(row.fixed ? row.want : outcome);
   endtask

   // register write only once the queue has gone quiet
   task automatic set_never(logic [63:0] value);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      never_value = value;
   endtask

   task automatic run_random(int count, int insert_pct, bit quiet, int hold_at);
      calm = quiet;
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) hold_wanted = 1'b1;
         offer(open_row(random_command(insert_pct)));
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin : response_side
      dqe_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            report_fault("unexpected result", '0, rsp_data);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.popped_valid !== want.popped_valid
                || rsp_data.popped_task !== want.popped_task
                || rsp_data.popped_deadline !== want.popped_deadline)
               report_fault("result mismatch", want, rsp_data);
         end
      end
      if (hold_wanted && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_POP, 8'h00, '0, '0, MAX_TIME),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_REMOVE, 8'hFF, '0, '0, '0),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(CMD_SPARE, 8'hA5, MAX_TIME, '1, MAX_TIME),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_INSERT, 8'hFF, MAX_TIME, '0, '0),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_POP, 8'h00, '0, '0, MAX_TIME),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(open_row(make_req(dqe_pkg::CMD_INSERT, 8'h01, '0, '0, '0)));
      script.push_back(open_row(make_req(dqe_pkg::CMD_INSERT, 8'h00, '0, '0, '0)));
      script.push_back(open_row(make_req(dqe_pkg::CMD_INSERT, 8'h02, '0, '1, '0)));
      script.push_back(open_row(make_req(dqe_pkg::CMD_INSERT, 8'h03, MAX_TIME - 1,
                                         32'd1, '0)));
      script.push_back(open_row(make_req(dqe_pkg::CMD_INSERT, 8'hFF, MAX_TIME - 1,
                                         32'd1, '0)));
      for (int i = 4; i < 15; i++)
         script.push_back(open_row(make_req(dqe_pkg::CMD_INSERT, 8'(i), 64'h100 * i,
                                            $urandom, '0)));
      // queue is full here
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_INSERT, 8'h80, 64'd7, '0, '0),
                                 dqe_pkg::STATUS_FULL, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_INSERT, 8'h00, 64'd7, '0, '0),
                                 dqe_pkg::STATUS_DUP, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_INSERT, 8'h80, MAX_TIME, '0, '0),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_POP, 8'h00, '0, '0, '0),
                                 dqe_pkg::STATUS_OK, 1'b1, 8'h00, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_POP, 8'h00, '0, '0, '0),
                                 dqe_pkg::STATUS_OK, 1'b1, 8'h01, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_REMOVE, 8'h02, '0, '0, '0),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(fixed_row(make_req(dqe_pkg::CMD_POP, 8'h00, '0, '0, 64'h3FF),
                                 dqe_pkg::STATUS_OK, 1'b0, '0, '0));
      script.push_back(open_row(make_req(dqe_pkg::CMD_POP, 8'h00, '0, '0, MAX_TIME - 2)));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_never(MAX_TIME);
      foreach (script[i]) offer(script[i]);

      set_never('0);
      run_random(325, 60, 1'b0, -1);
      set_never(MAX_TIME);
      run_random(325, 45, 1'b1, -1);
      set_never({$urandom, $urandom});
      run_random(325, 70, 1'b0, 100);
      set_never(now_ns + 64'd50);
      run_random(325, 50, 1'b0, -1);
      req_valid <= 1'b0;

      for (int n = 0; n < 4000 && due_results.size() != 0; n++) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("tb_top: %0d results never arrived", due_results.size());
         fault_count += due_results.size();
      end
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
